// ===== design/mdmd_pkg.sv =====
// Shared constants, types and helpers for the meter disk mark detector
package mdmd_pkg;

	localparam int WINDOW_DEF      = 200;
	localparam int RANK_STEP_DEF   = 10;
	localparam int SAMPLE_BITS_DEF = 10;

	localparam logic [31:0] ENERGY_MS_PER_KWH = 32'd3600000000;

	typedef enum logic [2:0] {
		REG_HIGH_THR = 3'd0,
		REG_LOW_THR  = 3'd1,
		REG_TURNS    = 3'd2,
		REG_MAX_W    = 3'd3,
		REG_DEV_PCT  = 3'd4
	} reg_idx_t;

	// control travelling from the top level sequencer to the cell row
	typedef struct packed {
		logic remove;  // drop first cell equal to old value
		logic insert;  // insert new value in order
	} row_ctl_t;

	// clamp a rank index into the window
	function automatic int rank_idx(input int w, input int step, input int k, input bit up);
		int idx;
		begin
			idx = up ? (w / 2 + k * step) : (w / 2 - k * step);
			if (idx < 0) idx = 0;
			if (idx > w - 1) idx = w - 1;
			return idx;
		end
	endfunction

endpackage

// ===== design/mdmd_cell.sv =====
// One cell of the sorted window row: holds a value, shifts with its neighbours
module mdmd_cell #(
	parameter int SB = mdmd_pkg::SAMPLE_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mdmd_pkg::row_ctl_t ctl,
	input  logic [SB-1:0] old_v,
	input  logic [SB-1:0] new_v,
	input  logic [SB-1:0] left_val,   // value of lower neighbour
	input  logic [SB-1:0] right_val,  // value of upper neighbour
	input  logic          left_hit,   // some lower cell holds old_v
	input  logic          left_gt,    // lower neighbour > new_v
	input  logic          is_last,
	output logic [SB-1:0] val,
	output logic          hit_out,    // this or a lower cell holds old_v
	output logic          gt_out
);

	logic [SB-1:0] val_q;
	logic          hit_here;

	assign val      = val_q;
	assign hit_here = !left_hit && (val_q == old_v);
	assign hit_out  = left_hit || (val_q == old_v);
	assign gt_out   = val_q > new_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (ctl.remove) begin
			// from the removed place on, take the upper neighbour
			if (left_hit || hit_here)
				val_q <= is_last ? val_q : right_val;
		end else if (ctl.insert) begin
			// last cell is free after removal; cells above the slot shift up
			if (left_gt)
				val_q <= left_val;
			else if (gt_out || is_last)
				val_q <= new_v;
		end
	end

endmodule

// ===== design/mdmd_div.sv =====
// Restoring divider, one quotient bit per cycle
module mdmd_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [39:0] divisor,
	output logic        busy,
	output logic [31:0] quot
);

	logic [5:0]  cnt_q;
	logic [31:0] dend_q;
	logic [40:0] rem_q;
	logic [39:0] dsr_q;
	logic [31:0] q_q;
	logic [40:0] trial;

	assign busy  = cnt_q != '0;
	assign quot  = q_q;
	assign trial = {rem_q[39:0], dend_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= 6'd32;
		end else if (busy) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dend_q <= mdmd_pkg::ENERGY_MS_PER_KWH;
			rem_q  <= '0;
			dsr_q  <= divisor;
			q_q    <= '0;
		end else if (busy) begin
			dend_q <= {dend_q[30:0], 1'b0};
			if (trial >= {1'b0, dsr_q}) begin
				rem_q <= trial - {1'b0, dsr_q};
				q_q   <= {q_q[30:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[30:0], 1'b0};
			end
		end
	end

endmodule

// ===== design/meter_disk_mark_detector_unit.sv =====
// Top level of the meter disk mark detector
// Usage:
//  s_axis carries one sample word: tdata[9:0] sample, tdata[41:10] time_ms.
//  m_axis returns one result word per sample (fields listed at the port).
//  cfg writes register cfg_index (0..4) with cfg_data; write only when idle.
// Steps: an accepted sample reads the old entry, removes it from the sorted
//  cell row, inserts the new value, sums the ranks and loads the output
//  register; when a mark triggers the consumption division, the 32 quotient
//  bits (one a cycle) and the outcome come before the output register load.
// Input: a new sample is taken only once the unit is idle again, through
//  with the previous sample; the previous result word may still wait in
//  the output register meanwhile.
// Reset: sorted row and all counters clear to zero, registers take their
//  default values, the window memory is not reset but reads as zero until
//  it wraps; a stalled receiver holds the result, the following sample is
//  processed up to its output step and then waits, which stops further input.
module meter_disk_mark_detector_unit #(
	parameter int WINDOW      = mdmd_pkg::WINDOW_DEF,
	parameter int RANK_STEP   = mdmd_pkg::RANK_STEP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // sample[9:0], time_ms[41:10], zero pad
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// rank_sum[12:0], mark_state[13], turn_event[14], outlier[15],
	// consumption_w[31:16], publish[32], turn_count[64:33], zero pad
	output logic [71:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int PW = $clog2(WINDOW + 1);
	localparam int AW = $clog2(WINDOW);
	localparam int SB = mdmd_pkg::SAMPLE_BITS_DEF;

	typedef enum logic [2:0] {
		ST_IDLE, ST_READ, ST_REMOVE, ST_INSERT, ST_SUM, ST_DIV, ST_OUT
	} state_t;

	state_t state_q;

	logic [7:0]  hi_thr_q, lo_thr_q, turns_q;
	logic [15:0] max_w_q;
	logic [6:0]  dev_q;

	logic [SB-1:0] win_mem [WINDOW];
	logic [SB-1:0] old_q, new_q;
	logic [31:0]   now_q;
	logic [PW-1:0] wpos_q;
	logic          full_q;
	logic [7:0]    hrun_q, lrun_q;
	logic          mark_q;
	logic [31:0]   last_t_q;
	logic [15:0]   last_pub_q, latest_q;
	logic [31:0]   turns_tot_q;
	logic [12:0]   sum_q;
	logic          turn_q, outl_q, pub_q, outv_q;
	logic [71:0]   out_q;

	mdmd_pkg::row_ctl_t ctl;
	logic [SB-1:0] cval [WINDOW];
	logic          chit [WINDOW];
	logic          cgt  [WINDOW];

	assign ctl.remove = state_q == ST_REMOVE;
	assign ctl.insert = state_q == ST_INSERT;

	for (genvar g = 0; g < WINDOW; g++) begin : g_row
		mdmd_cell #(.SB(SB)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.old_v(old_q), .new_v(new_q),
			.left_val ((g == 0) ? new_q : cval[(g == 0) ? 0 : g - 1]),
			.right_val(cval[(g == WINDOW - 1) ? g : g + 1]),
			.left_hit ((g == 0) ? 1'b0 : chit[(g == 0) ? 0 : g - 1]),
			.left_gt  ((g == 0) ? 1'b0 : cgt[(g == 0) ? 0 : g - 1]),
			.is_last  (g == WINDOW - 1),
			.val(cval[g]), .hit_out(chit[g]), .gt_out(cgt[g])
		);
	end

	logic [12:0] rsum;
	always_comb begin
		rsum = '0;
		for (int k = 1; k <= 4; k++) begin
			rsum = rsum + 13'(cval[mdmd_pkg::rank_idx(WINDOW, RANK_STEP, k, 1'b1)]);
			rsum = rsum + 13'(cval[mdmd_pkg::rank_idx(WINDOW, RANK_STEP, k, 1'b0)]);
		end
	end

	logic [31:0] elapsed;
	logic [39:0] prod;
	logic        div_start, div_busy;
	logic [31:0] quot;
	logic [15:0] qsat;
	logic [15:0] diff;
	logic        high_s;
	logic [7:0]  hrun_n;

	assign elapsed = now_q - last_t_q;
	assign prod    = 40'(turns_q) * 40'(elapsed);
	assign qsat    = (quot > 32'd65535) ? 16'hFFFF : quot[15:0];
	assign diff    = (qsat >= last_pub_q) ? qsat - last_pub_q : last_pub_q - qsat;
	assign high_s  = ({1'b0, new_q, 3'b0} >= {1'b0, rsum} + 14'd20) ;
	assign hrun_n  = (hrun_q == 8'hFF) ? hrun_q : hrun_q + 8'd1;
	assign div_start = (state_q == ST_SUM) && high_s && !mark_q
		&& (hrun_n >= hi_thr_q) && (prod != '0);

	mdmd_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .divisor(prod),
		.busy(div_busy), .quot(quot)
	);

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = outv_q;
	assign m_axis_tdata  = out_q;

	// entries not yet written since reset read as zero until the window wraps
	always_ff @(posedge clk) begin
		if (state_q == ST_READ)
			win_mem[wpos_q[AW-1:0]] <= new_q;
		if (state_q == ST_READ)
			old_q <= full_q ? win_mem[wpos_q[AW-1:0]] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hi_thr_q <= 8'd3; lo_thr_q <= 8'd10; turns_q <= 8'd120;
			max_w_q <= 16'd13800; dev_q <= 7'd5;
			new_q <= '0; now_q <= '0;
			wpos_q <= '0; full_q <= 1'b0; hrun_q <= '0; lrun_q <= '0;
			mark_q <= 1'b0; last_t_q <= '0; last_pub_q <= '0; latest_q <= '0;
			turns_tot_q <= '0; sum_q <= '0;
			turn_q <= 1'b0; outl_q <= 1'b0; pub_q <= 1'b0;
			outv_q <= 1'b0; out_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					mdmd_pkg::REG_HIGH_THR: hi_thr_q <= cfg_data[7:0];
					mdmd_pkg::REG_LOW_THR:  lo_thr_q <= cfg_data[7:0];
					mdmd_pkg::REG_TURNS:    turns_q  <= cfg_data[7:0];
					mdmd_pkg::REG_MAX_W:    max_w_q  <= cfg_data;
					mdmd_pkg::REG_DEV_PCT:  dev_q    <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (outv_q && m_axis_tready && state_q != ST_OUT)
				outv_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (s_axis_tvalid && s_axis_tready) begin
					new_q <= s_axis_tdata[SB-1:0];
					now_q <= s_axis_tdata[41:10];
					if (wpos_q >= PW'(WINDOW)) begin
						wpos_q <= '0;
						full_q <= 1'b1;
					end
					state_q <= ST_READ;
				end
				ST_READ: begin
					wpos_q  <= wpos_q + PW'(1);
					state_q <= ST_REMOVE;
				end
				ST_REMOVE: state_q <= ST_INSERT;
				ST_INSERT: state_q <= ST_SUM;
				ST_SUM: begin
					sum_q <= rsum;
					turn_q <= 1'b0; outl_q <= 1'b0; pub_q <= 1'b0;
					state_q <= ST_OUT;
					if (high_s) begin
						lrun_q <= '0;
						hrun_q <= hrun_n;
						if (hrun_n >= hi_thr_q && !mark_q) begin
							if (prod == '0) begin
								latest_q <= 16'hFFFF;
								outl_q <= 1'b1;
							end else begin
								state_q <= ST_DIV;
							end
						end
					end else begin
						hrun_q <= '0;
						if (lrun_q != 8'hFF) begin
							lrun_q <= lrun_q + 8'd1;
							if (lrun_q + 8'd1 >= lo_thr_q) mark_q <= 1'b0;
						end else if (lrun_q >= lo_thr_q) begin
							mark_q <= 1'b0;
						end
					end
				end
				ST_DIV: if (!div_busy && !div_start) begin
					latest_q <= qsat;
					if (quot <= 32'(max_w_q)) begin
						mark_q <= 1'b1;
						turn_q <= 1'b1;
						turns_tot_q <= turns_tot_q + 32'd1;
						last_t_q <= now_q;
						if (full_q && last_t_q != '0 &&
							(24'(diff) * 24'd100 >= 24'(last_pub_q) * 24'(dev_q))) begin
							pub_q <= 1'b1;
							last_pub_q <= qsat;
						end
					end else begin
						outl_q <= 1'b1;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: if (!outv_q || m_axis_tready) begin
					out_q <= {7'b0, turns_tot_q, pub_q, latest_q, outl_q, turn_q,
						mark_q, sum_q};
					outv_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== test/meter_disk_mark_detector_unit_tb.sv =====
// Self-checking testbench for the meter disk mark detector: streamed samples, predicted results
module meter_disk_mark_detector_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN = 200;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [31:0] time_ms;
		logic [9:0]  sample;
	} sample_word_t;

	typedef struct packed {
		logic [31:0] turn_count;
		logic        publish;
		logic [15:0] consumption_w;
		logic        outlier;
		logic        turn_event;
		logic        mark_state;
		logic [12:0] rank_sum;
	} result_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	meter_disk_mark_detector_unit i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [7:0] high_thr, low_thr, turns_kwh;
	logic [15:0] max_w;
	logic [6:0] dev_pct;
	logic [9:0] ring[WIN];
	logic [9:0] ordered[WIN];
	int wr_pos;
	bit win_full, mark_on;
	int high_len, low_len;
	logic [31:0] last_turn_ms, turns_total;
	logic [15:0] published_w, consumption;

	sample_word_t pending_samples[$];
	result_word_t expected_results[$];
	int errors = 0;
	int send_idle = 28, recv_idle = 53;
	int quiet_cycles = 0;
	bit timed_out = 0;
	bit in_taken = 0;

	task automatic reset_predictor();
		high_thr = 3; low_thr = 10; turns_kwh = 120; max_w = 13800; dev_pct = 5;
		foreach (ring[i]) begin
			ring[i] = '0;
			ordered[i] = '0;
		end
		wr_pos = 0; win_full = 0; mark_on = 0; high_len = 0; low_len = 0;
		last_turn_ms = 0; turns_total = 0; published_w = 0; consumption = 0;
	endtask

	function automatic result_word_t predict_detection(sample_word_t w);
		result_word_t r;
		logic [9:0] old_v;
		int rm, ins;
		int sum;
		logic [31:0] elapsed;
		longint unsigned prod, q, diff;
		r = '0;
		if (wr_pos >= WIN) begin
			wr_pos = 0;
			win_full = 1;
		end
		old_v = ring[wr_pos];
		ring[wr_pos] = w.sample;
		wr_pos++;
		rm = WIN - 1;
		for (int k = 0; k < WIN; k++)
			if (ordered[k] == old_v) begin
				rm = k;
				break;
			end
		for (int k = rm; k < WIN - 1; k++) ordered[k] = ordered[k + 1];
		ins = WIN - 1;
		for (int k = 0; k < WIN - 1; k++)
			if (ordered[k] > w.sample) begin
				ins = k;
				break;
			end
		for (int k = WIN - 1; k > ins; k--) ordered[k] = ordered[k - 1];
		ordered[ins] = w.sample;
		sum = 0;
		for (int k = 1; k <= 4; k++) sum += ordered[100 + k * 10] + ordered[100 - k * 10];
		if (int'(w.sample) * 8 >= sum + 20) begin
			low_len = 0;
			if (high_len < 255) high_len++;
			if (high_len >= high_thr && !mark_on) begin
				elapsed = w.time_ms - last_turn_ms;
				prod = longint'(turns_kwh) * longint'(elapsed);
				if (prod == 0) begin
					consumption = 16'hFFFF;
					r.outlier = 1;
				end else begin
					q = 64'd3600000000 / prod;
					consumption = q > 65535 ? 16'hFFFF : q[15:0];
					if (q <= max_w) begin
						mark_on = 1;
						r.turn_event = 1;
						turns_total++;
						diff = q >= published_w ? q - published_w : published_w - q;
						if (win_full && last_turn_ms != 0 &&
								diff * 100 >= longint'(published_w) * dev_pct) begin
							r.publish = 1;
							published_w = q[15:0];
						end
						last_turn_ms = w.time_ms;
					end else
						r.outlier = 1;
				end
			end
		end else begin
			high_len = 0;
			if (low_len < 255) low_len++;
			if (low_len >= low_thr && mark_on) mark_on = 0;
		end
		r.rank_sum = sum[12:0];
		r.mark_state = mark_on;
		r.consumption_w = consumption;
		r.turn_count = turns_total;
		return r;
	endfunction

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_axis_tdata <= {6'b0, pending_samples[0]};
					s_axis_tvalid <= 1'b1;
					void'(pending_samples.pop_front());
				end else
					s_axis_tvalid <= 1'b0;
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor and predictor feed
	always @(posedge clk) begin
		result_word_t got, exp_r;
		in_taken = s_axis_tvalid && s_axis_tready;
		if (s_axis_tvalid && s_axis_tready)
			expected_results.push_back(predict_detection(s_axis_tdata[41:0]));
		if (m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[64:0];
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h", $time, got);
			end else begin
				exp_r = expected_results.pop_front();
				if (got !== exp_r || m_axis_tdata[71:65] !== '0) begin
					errors++;
					$display("%0t: mismatch expected %h actual %h", $time, exp_r, m_axis_tdata);
				end
			end
		end
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	always @(posedge clk)
		if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("Testbench completed WITH ERRORS");
			$finish;
		end

	task automatic write_reg(mdmd_pkg::reg_idx_t idx, logic [15:0] val);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			mdmd_pkg::REG_HIGH_THR: high_thr = val[7:0];
			mdmd_pkg::REG_LOW_THR:  low_thr = val[7:0];
			mdmd_pkg::REG_TURNS:    turns_kwh = val[7:0];
			mdmd_pkg::REG_MAX_W:    max_w = val;
			mdmd_pkg::REG_DEV_PCT:  dev_pct = val[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (pending_samples.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic queue_sample(int s, logic [31:0] t);
		sample_word_t w;
		w.sample = s[9:0];
		w.time_ms = t;
		pending_samples.push_back(w);
	endtask

	// bursts of dark baseline with reflective marks, plus noise
	task automatic queue_rotations(int n, ref logic [31:0] t, input int step_hi);
		int base;
		base = $urandom_range(60, 300);
		for (int i = 0; i < n; i++) begin
			t += $urandom_range(1, step_hi);
			if ($urandom_range(99) < 5)
				queue_sample($urandom_range(1023), $urandom);
			else if ((i % 40) < 5)
				queue_sample($urandom_range(base + 40, 1023), t);
			else
				queue_sample(base + $urandom_range(0, 4), t);
		end
	endtask

	initial begin
		logic [31:0] t;
		reset_predictor();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, zero elapsed, zero threshold, outliers
		queue_sample(0, 0);
		queue_sample(1023, 0);
		queue_sample(1023, 32'hFFFF_FFFF);
		queue_sample(1023, 32'hFFFF_FFFF);
		queue_sample(1023, 1);
		for (int i = 0; i < 12; i++) queue_sample(0, 32'h5555_5555);
		queue_sample(1023, 32'hAAAA_AAAA);
		queue_sample(1023, 32'hAAAA_AAAA + 1000);
		queue_sample(1023, 32'hAAAA_AAAA + 400000);
		queue_sample(512, 32'h8000_0000);
		drain();
		write_reg(mdmd_pkg::REG_HIGH_THR, 0);
		write_reg(mdmd_pkg::REG_LOW_THR, 0);
		write_reg(mdmd_pkg::REG_TURNS, 255);
		write_reg(mdmd_pkg::REG_MAX_W, 65535);
		write_reg(mdmd_pkg::REG_DEV_PCT, 0);
		queue_sample(1023, 5);
		queue_sample(0, 6);
		queue_sample(1023, 7);
		queue_sample(1023, 8);
		drain();

		// random phases through several settings
		t = 32'hFFFF_0000;
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					write_reg(mdmd_pkg::REG_HIGH_THR, 3); write_reg(mdmd_pkg::REG_LOW_THR, 10);
					write_reg(mdmd_pkg::REG_TURNS, 1); write_reg(mdmd_pkg::REG_MAX_W, 65535);
					write_reg(mdmd_pkg::REG_DEV_PCT, 100);
				end
				1: begin
					write_reg(mdmd_pkg::REG_HIGH_THR, 255); write_reg(mdmd_pkg::REG_LOW_THR, 255);
					write_reg(mdmd_pkg::REG_TURNS, 120); write_reg(mdmd_pkg::REG_MAX_W, 0);
					write_reg(mdmd_pkg::REG_DEV_PCT, 5);
				end
				2: begin
					write_reg(mdmd_pkg::REG_HIGH_THR, 2); write_reg(mdmd_pkg::REG_LOW_THR, 3);
					write_reg(mdmd_pkg::REG_TURNS, 75); write_reg(mdmd_pkg::REG_MAX_W, 13800);
					write_reg(mdmd_pkg::REG_DEV_PCT, 1);
				end
				default: begin
					write_reg(mdmd_pkg::REG_HIGH_THR, 1); write_reg(mdmd_pkg::REG_LOW_THR, 1);
					write_reg(mdmd_pkg::REG_TURNS, 200); write_reg(mdmd_pkg::REG_MAX_W, 40000);
					write_reg(mdmd_pkg::REG_DEV_PCT, 10);
				end
			endcase
			if (ph == 1) begin
				send_idle = 53; recv_idle = 28;
			end else if (ph == 3) begin
				send_idle = 0; recv_idle = 0;
			end
			queue_rotations(150, t, ph == 0 ? 40000 : 300);
			drain();
		end

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/mdmd_pkg.sv
design/mdmd_cell.sv
design/mdmd_div.sv
design/meter_disk_mark_detector_unit.sv
test/meter_disk_mark_detector_unit_tb.sv
